>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define SLRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");

// expression must never be true out of reset
`define SLRT_ASSERT_NEVER(lbl, expr) \
  `SLRT_ASSERT(lbl, !(expr))

`endif

>>> rtl/core/slrt_pkg.sv
// shared types and constants of the sequence loss and reorder tracker
`timescale 1ns / 1ps
package slrt_pkg;

  localparam int SLRT_MAP_BITS = 256;
  localparam int SLRT_QUEUE_DEPTH = 2;

  localparam int SEQ_W     = 64;
  localparam int CNT_W     = 64;
  localparam int WIN_W     = 9;
  localparam int WRAP_W    = 32;
  localparam int DEAD_W    = 8;
  localparam int VERDICT_W = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [WIN_W-1:0]  WIN_RST  = 9'd256;
  localparam logic [WRAP_W-1:0] WRAP_RST = 32'h4000_0000;
  localparam logic [DEAD_W-1:0] DEAD_RST = 8'd25;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_WRAP   = 2'd1;
  localparam logic [1:0] REG_DEAD   = 2'd2;

  // verdict codes
  localparam logic [VERDICT_W-1:0] V_ADVANCE = 3'd0;
  localparam logic [VERDICT_W-1:0] V_JUMP    = 3'd1;
  localparam logic [VERDICT_W-1:0] V_DUP     = 3'd2;
  localparam logic [VERDICT_W-1:0] V_REORDER = 3'd3;
  localparam logic [VERDICT_W-1:0] V_STALE   = 3'd4;
  localparam logic [VERDICT_W-1:0] V_WRAP    = 3'd5;
  localparam logic [VERDICT_W-1:0] V_DEAD    = 3'd6;

  typedef struct packed {
    logic [WIN_W-1:0]  win_len;
    logic [WRAP_W-1:0] wrap_threshold;
    logic [DEAD_W-1:0] dead_limit;
  } cfg_t;

  // queue head toward the tracker engine
  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq;
  } q_head_t;

endpackage

>>> rtl/core/slrt_front.sv
// input queue that decouples packet intake from the tracker engine
`timescale 1ns / 1ps
module slrt_front
  import slrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SEQ_W-1:0] in_seq,
  output q_head_t          head,
  input  logic             pop
);

  localparam int PTR_W = $clog2(SLRT_QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(SLRT_QUEUE_DEPTH + 1);

  logic [SEQ_W-1:0]  mem_r [SLRT_QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              push;

  assign in_stall = (count_r == CNT_QW'(SLRT_QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign head.valid = (count_r != '0);
  assign head.seq   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_QW'(1);
    else if (pop && !push) count_nxt = count_r - CNT_QW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(SLRT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(SLRT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_seq;
  end

endmodule

>>> rtl/core/slrt_back.sv
// tracker engine: bitmap, highest number, counters and result register
`timescale 1ns / 1ps
module slrt_back
  import slrt_pkg::*;
#(
  parameter int MAP_BITS = SLRT_MAP_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  q_head_t              head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] out_verdict,
  output logic [CNT_W-1:0]     out_rx_count,
  output logic [CNT_W-1:0]     out_lost_count,
  output logic [CNT_W-1:0]     out_dup_count,
  output logic [CNT_W-1:0]     out_reorder_count
);

  localparam int IDX_W = $clog2(MAP_BITS);

  logic [MAP_BITS-1:0]  map_r, map_nxt;
  logic [SEQ_W-1:0]     high_r, high_nxt;
  logic [DEAD_W-1:0]    stale_r, stale_nxt;
  logic [CNT_W-1:0]     rx_r, lost_r, dup_r, reo_r;
  logic [CNT_W-1:0]     rx_nxt, lost_nxt, dup_nxt, reo_nxt;
  logic [VERDICT_W-1:0] verdict_nxt;
  logic                 out_valid_r;
  logic [VERDICT_W-1:0] verdict_r;

  logic [SEQ_W-1:0]  s, dfw, dbk, gap;
  logic [IDX_W-1:0]  slot_s, slot_h, off;
  logic [WRAP_W-1:0] a, b;
  logic [DEAD_W-1:0] stale_inc;
  logic              adv, in_win, gap_all;
  logic [MAP_BITS-1:0] restart_map;

  assign pop = head.valid && (!out_valid_r || !out_stall);

  always_comb begin
    s       = head.seq;
    adv     = s > high_r;
    dfw     = s - high_r;
    dbk     = high_r - s;
    gap     = dfw - SEQ_W'(1);
    gap_all = gap >= SEQ_W'(MAP_BITS);
    slot_s  = s[IDX_W-1:0];
    slot_h  = high_r[IDX_W-1:0];
    a       = high_r[WRAP_W-1:0];
    b       = s[WRAP_W-1:0];
    stale_inc = (stale_r == '1) ? stale_r : stale_r + DEAD_W'(1);
    restart_map = '0;
    restart_map[slot_s] = 1'b1;
    off = '0;

    map_nxt     = map_r;
    high_nxt    = high_r;
    stale_nxt   = stale_r;
    rx_nxt      = rx_r + CNT_W'(1);
    lost_nxt    = lost_r;
    dup_nxt     = dup_r;
    reo_nxt     = reo_r;
    verdict_nxt = V_STALE;

    if (adv) begin
      in_win    = dfw < SEQ_W'(cfg.win_len);
      stale_nxt = '0;
      lost_nxt  = lost_r + gap;
      high_nxt  = s;
      if (in_win) begin
        verdict_nxt = V_ADVANCE;
        // clear the skipped slots just past the old highest number
        for (int i = 0; i < MAP_BITS; i++) begin
          off = IDX_W'(i) - slot_h - IDX_W'(1);
          if (gap_all || (off < gap[IDX_W-1:0])) map_nxt[i] = 1'b0;
        end
      end else begin
        verdict_nxt = V_JUMP;
        map_nxt = '0;
      end
      map_nxt[slot_s] = 1'b1;
    end else begin
      in_win = dbk < SEQ_W'(cfg.win_len);
      if (in_win) begin
        if (map_r[slot_s]) begin
          verdict_nxt = V_DUP;
          dup_nxt = dup_r + CNT_W'(1);
        end else begin
          verdict_nxt = V_REORDER;
          reo_nxt  = reo_r + CNT_W'(1);
          lost_nxt = lost_r - CNT_W'(1);
          map_nxt[slot_s] = 1'b1;
        end
      end else if ((a > b) && ((a - b) > cfg.wrap_threshold)) begin
        verdict_nxt = V_WRAP;
        map_nxt  = restart_map;
        high_nxt = s;
      end else if (stale_inc > cfg.dead_limit) begin
        verdict_nxt = V_DEAD;
        stale_nxt = '0;
        map_nxt   = restart_map;
        high_nxt  = s;
      end else begin
        verdict_nxt = V_STALE;
        stale_nxt = stale_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      high_r      <= '0;
      stale_r     <= '0;
      rx_r        <= '0;
      lost_r      <= '0;
      dup_r       <= '0;
      reo_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      map_r       <= map_nxt;
      high_r      <= high_nxt;
      stale_r     <= stale_nxt;
      rx_r        <= rx_nxt;
      lost_r      <= lost_nxt;
      dup_r       <= dup_nxt;
      reo_r       <= reo_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) verdict_r <= verdict_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_rx_count      = rx_r;
  assign out_lost_count    = lost_r;
  assign out_dup_count     = dup_r;
  assign out_reorder_count = reo_r;

endmodule

>>> rtl/core/sequence_loss_reorder_tracker_unit.sv
// top level of the sequence loss and reorder tracker
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   in       | in_valid/in_stall | in_seq
//   out      | out_valid/out_stall | out_verdict, out_*_count
//   cfg      | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// one packet per cycle sustained while out_stall is low; an item passes through the input queue
// and then the tracker engine, which updates the whole bitmap for each packet it takes
// no clearing pass after reset: the bitmap is flops, cleared by reset at once
// reset is synchronous, active low; clears queue, state and counters
// a stalled result holds in the output register while the two-entry queue
// keeps taking packets until it fills
`timescale 1ns / 1ps
module sequence_loss_reorder_tracker_unit
  import slrt_pkg::*;
#(
  parameter int MAP_BITS = SLRT_MAP_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // packet intake
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SEQ_W-1:0]     in_seq,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] out_verdict,
  output logic [CNT_W-1:0]     out_rx_count,
  output logic [CNT_W-1:0]     out_lost_count,
  output logic [CNT_W-1:0]     out_dup_count,
  output logic [CNT_W-1:0]     out_reorder_count,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  cfg_t       cfg_r;
  q_head_t    head;
  logic       pop;
  logic [1:0] reg_idx;
  logic       wr_en;

  // register file: word index from the byte address
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_len        <= WIN_RST;
      cfg_r.wrap_threshold <= WRAP_RST;
      cfg_r.dead_limit     <= DEAD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW: cfg_r.win_len        <= pwdata[WIN_W-1:0];
        REG_WRAP:   cfg_r.wrap_threshold <= pwdata[WRAP_W-1:0];
        REG_DEAD:   cfg_r.dead_limit     <= pwdata[DEAD_W-1:0];
        default:    ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = DATA_W'(cfg_r.win_len);
      REG_WRAP:   prdata = cfg_r.wrap_threshold;
      REG_DEAD:   prdata = DATA_W'(cfg_r.dead_limit);
      default:    prdata = '0;
    endcase
  end

  // front: intake queue
  slrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_seq   (in_seq),
    .head     (head),
    .pop      (pop)
  );

  // back: classification, bitmap update and result register
  slrt_back #(.MAP_BITS(MAP_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_rx_count      (out_rx_count),
    .out_lost_count    (out_lost_count),
    .out_dup_count     (out_dup_count),
    .out_reorder_count (out_reorder_count)
  );

endmodule

>>> rtl/core/slrt_checker.sv
// port-level checks of the tracker, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slrt_checker
  import slrt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VERDICT_W-1:0] out_verdict,
  input logic [CNT_W-1:0]     out_rx_count
);

  `SLRT_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid)
  `SLRT_ASSERT(a_out_stable, (out_valid && out_stall) |=> $stable(out_rx_count))
  `SLRT_ASSERT_NEVER(a_verdict_range, out_valid && (out_verdict > V_DEAD))
  `SLRT_ASSERT(a_rx_moves, (out_valid && !out_stall) ##1 out_valid |-> (out_rx_count != $past(out_rx_count)))

endmodule

bind sequence_loss_reorder_tracker_unit slrt_checker u_slrt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_verdict  (out_verdict),
  .out_rx_count (out_rx_count)
);
